>>> rtl/planar_tile_blitter_2bpp_core_macros.svh
// Assertion macros for the tile blitter RTL.
`ifndef PLANAR_TILE_BLITTER_2BPP_CORE_MACROS_SVH
`define PLANAR_TILE_BLITTER_2BPP_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define PTB_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ptb: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PTB_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ptb: next-cycle check failed");

`else

`define PTB_ASSERT_IMPLY(name, clk, rstn, ante, cons)
`define PTB_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/ptb_pkg.sv
// Shared constants, codes and types of the planar tile blitter.
`timescale 1ns / 1ps
package ptb_pkg;

    localparam int NUM_TILES       = 256;
    localparam int PALETTE_COUNT   = 8;
    localparam int MAX_TARGET_SIZE = 1024;

    localparam int BYTES_PER_TILE = 16;
    localparam int PATTERN_DEPTH  = NUM_TILES * BYTES_PER_TILE;
    localparam int PALETTE_DEPTH  = PALETTE_COUNT * 4;

    localparam int TILE_AW    = $clog2(NUM_TILES);
    localparam int PAT_AW     = TILE_AW + 4;          // byte address
    localparam int ROW_AW     = TILE_AW + 3;          // one bank row per tile line
    localparam int PAL_NUM_W  = $clog2(PALETTE_COUNT);
    localparam int PAL_AW     = PAL_NUM_W + 2;

    localparam int SIZE_W  = 11;
    localparam int COORD_W = 10;
    localparam int COLOR_W = 32;

    localparam int PIX_W = 6;
    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(63);

    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - COLOR_W - 2 * COORD_W;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(240);

    localparam logic [1:0] CFG_TARGET_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_TARGET_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD_PATTERN = 2'd0,
        OP_LOAD_PALETTE = 2'd1,
        OP_PLACE        = 2'd2
    } ptb_op_t;

    typedef enum logic [1:0] {
        PTB_IDLE,
        PTB_ISSUE,
        PTB_DRAIN
    } ptb_state_t;

    typedef struct packed {
        logic [TILE_AW-1:0]   tile;
        logic [PAL_NUM_W-1:0] pal;
        logic signed [10:0]   dx;
        logic signed [10:0]   dy;
        logic                 eof;
        logic [SIZE_W-1:0]    width;
        logic [SIZE_W-1:0]    height;
    } ptb_place_t;

    typedef struct packed {
        logic              en;
        logic [PAT_AW-1:0] addr;
        logic [7:0]        data;
    } ptb_pat_wr_t;

    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] row;
    } ptb_pat_rd_t;

    typedef struct packed {
        logic               en;
        logic [PAL_AW-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } ptb_pal_wr_t;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
    } ptb_pal_rd_t;

endpackage

>>> rtl/ptb_pattern_mem.sv
// Pattern store: two banks, low plane and high plane, read a tile line at once.
`timescale 1ns / 1ps
module ptb_pattern_mem (
    input  logic                aclk,
    input  ptb_pkg::ptb_pat_wr_t wr,
    input  ptb_pkg::ptb_pat_rd_t rd,
    output logic [7:0]          lo_q,
    output logic [7:0]          hi_q
);
    import ptb_pkg::*;

    localparam int BANK_DEPTH = PATTERN_DEPTH / 2;

    logic [7:0] lo_mem [BANK_DEPTH];
    logic [7:0] hi_mem [BANK_DEPTH];
    logic [ROW_AW-1:0] wr_row;

    // byte address bit 3 picks the plane
    assign wr_row = {wr.addr[PAT_AW-1:4], wr.addr[2:0]};

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            if (wr.addr[3]) begin
                hi_mem[wr_row] <= wr.data;
            end else begin
                lo_mem[wr_row] <= wr.data;
            end
        end
        if (rd.en) begin
            lo_q <= lo_mem[rd.row];
            hi_q <= hi_mem[rd.row];
        end
    end

endmodule

>>> rtl/ptb_palette_mem.sv
// Palette store: colour words, one write port and one registered read port.
`timescale 1ns / 1ps
module ptb_palette_mem (
    input  logic                        aclk,
    input  ptb_pkg::ptb_pal_wr_t        wr,
    input  ptb_pkg::ptb_pal_rd_t        rd,
    output logic [ptb_pkg::COLOR_W-1:0] q
);
    import ptb_pkg::*;

    logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            q <= mem[rd.addr];
        end
    end

endmodule

>>> rtl/ptb_blit_seq.sv
// Placement sequencer: pixel counter, decode and lookup stages, output register.
`timescale 1ns / 1ps
`include "planar_tile_blitter_2bpp_core_macros.svh"
module ptb_blit_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  ptb_pkg::ptb_place_t           cmd,
    output logic                          idle,
    output ptb_pkg::ptb_pat_rd_t          pat_rd,
    input  logic [7:0]                    pat_lo,
    input  logic [7:0]                    pat_hi,
    output ptb_pkg::ptb_pal_rd_t          pal_rd,
    input  logic [ptb_pkg::COLOR_W-1:0]   pal_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ptb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);
    import ptb_pkg::*;

    ptb_state_t state_reg, state_next;
    ptb_place_t cmd_reg;
    logic [PIX_W-1:0] k_reg, k_next;
    logic issue;
    logic adv;

    // stage 1: pattern line arriving
    logic v1_reg;
    logic [PIX_W-1:0] k1_reg;
    // stage 2: palette word arriving
    logic v2_reg;
    logic s2_opaque_reg, s2_inside_reg, s2_last_reg, s2_eof_reg;
    logic [COORD_W-1:0] s2_x_reg, s2_y_reg;
    // output register
    logic m_valid_reg, m_we_reg, m_last_reg, m_frame_reg;
    logic [COORD_W-1:0] m_x_reg, m_y_reg;
    logic [COLOR_W-1:0] m_color_reg;

    logic [2:0]  x1, y1, bit_sel;
    logic [1:0]  c1;
    logic [11:0] tx1, ty1;
    logic        inside1, we2;

    assign adv  = !m_valid_reg || m_tready;
    assign idle = (state_reg == PTB_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PTB_IDLE;
            k_reg       <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (adv) begin
                v1_reg      <= issue;
                v2_reg      <= v1_reg;
                m_valid_reg <= v2_reg;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        unique case (state_reg)
            PTB_IDLE: begin
                if (start) begin
                    state_next = PTB_ISSUE;
                    k_next     = '0;
                end
            end
            PTB_ISSUE: begin
                if (adv) begin
                    issue  = 1'b1;
                    k_next = k_reg + PIX_W'(1);
                    if (k_reg == PIX_LAST) begin
                        state_next = PTB_DRAIN;
                    end
                end
            end
            PTB_DRAIN: begin
                if (!v1_reg && (!v2_reg || adv)) begin
                    state_next = PTB_IDLE;
                end
            end
            default: state_next = PTB_IDLE;
        endcase
    end

    // one tile line per pixel read; both planes come back together
    assign pat_rd.en  = adv;
    assign pat_rd.row = {cmd_reg.tile, k_reg[PIX_W-1:3]};

    // stage 1 decode: leftmost pixel is bit 7
    always_comb begin
        x1      = k1_reg[2:0];
        y1      = k1_reg[PIX_W-1:3];
        bit_sel = ~x1;
        c1      = {pat_hi[bit_sel], pat_lo[bit_sel]};
        tx1     = {cmd_reg.dx[10], cmd_reg.dx} + {9'b0, x1};
        ty1     = {cmd_reg.dy[10], cmd_reg.dy} + {9'b0, y1};
        inside1 = !tx1[11] && (tx1[10:0] < cmd_reg.width)
               && !ty1[11] && (ty1[10:0] < cmd_reg.height);
    end

    assign pal_rd.en   = adv;
    assign pal_rd.addr = {cmd_reg.pal, c1};

    assign we2 = s2_opaque_reg && s2_inside_reg;

    always_ff @(posedge aclk) begin
        if (start && idle) begin
            cmd_reg <= cmd;
        end
        if (adv) begin
            k1_reg        <= k_reg;
            s2_opaque_reg <= (c1 != 2'b00);
            s2_inside_reg <= inside1;
            s2_x_reg      <= tx1[COORD_W-1:0];
            s2_y_reg      <= ty1[COORD_W-1:0];
            s2_last_reg   <= (k1_reg == PIX_LAST);
            s2_eof_reg    <= cmd_reg.eof;
            m_we_reg      <= we2;
            m_x_reg       <= we2 ? s2_x_reg : '0;
            m_y_reg       <= we2 ? s2_y_reg : '0;
            m_color_reg   <= we2 ? pal_data : '0;
            m_last_reg    <= s2_last_reg;
            m_frame_reg   <= s2_last_reg && s2_eof_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_color_reg, m_y_reg, m_x_reg};
    assign m_tuser  = {m_frame_reg, m_we_reg};
    assign m_tlast  = m_last_reg;

    `PTB_ASSERT_IMPLY(a_frame_on_last, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast)
    `PTB_ASSERT_IMPLY(a_masked_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0)
    `PTB_ASSERT_NEXT(a_start_issue, aclk, aresetn, start && idle, state_reg == PTB_ISSUE && k_reg == '0)
    `PTB_ASSERT_NEXT(a_stall_hold, aclk, aresetn, v2_reg && !adv, v2_reg && $stable(s2_x_reg))

endmodule

>>> rtl/planar_tile_blitter_2bpp_core.sv
// Top level of the planar 2bpp tile blitter: ports, config registers, stores, sequencer.
`timescale 1ns / 1ps
// Planar 2bpp tile blitter. Input beats either load one pattern byte, load one
// palette colour word, or place an 8x8 tile at a signed position; a placement
// yields 64 pixel beats, row by row, left to right, each flagged for writing
// when the pixel is opaque and inside the target. A placement gives one pixel a
// cycle, set by the single palette read port, while m_tready does not stall the
// output, once the pattern read, palette read and output stages fill; the next
// input beat is taken once the last pixel has moved into the output register. The
// pattern store is split into low and high plane banks so one read gives a
// whole tile line. Stores power up undefined: load every byte and colour a
// placement uses before placing. Target size writes saturate at 1024 and are
// only to be issued while the block is idle.
module planar_tile_blitter_2bpp_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata, low bit first: load_address[11:0], load_data[43:12],
    // tile_number[51:44], palette_number[54:52], dest_x[65:55],
    // dest_y[76:66], zero pad[79:77]
    input  logic [79:0]                   s_tdata,
    // tuser: operation
    input  logic [1:0]                    s_tuser,
    // tlast: end_of_frame
    input  logic                          s_tlast,
    // pixel beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata, low bit first: pixel_x[9:0], pixel_y[19:10],
    // pixel_color[51:20], zero pad[55:52]
    output logic [ptb_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser, low bit first: write_enable[0], frame_done[1]
    output logic [1:0]                    m_tuser,
    // tlast: last_pixel
    output logic                          m_tlast,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [ptb_pkg::SIZE_W-1:0]    cfg_data
);
    import ptb_pkg::*;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic              in_accept, idle, start;
    ptb_op_t           op;
    logic [PAT_AW-1:0] load_address;
    logic [COLOR_W-1:0] load_data;
    logic [PAL_NUM_W-1:0] pal_in;
    ptb_place_t        cmd;
    ptb_pat_wr_t       pat_wr;
    ptb_pat_rd_t       pat_rd;
    ptb_pal_wr_t       pal_wr;
    ptb_pal_rd_t       pal_rd;
    logic [7:0]        pat_lo, pat_hi;
    logic [COLOR_W-1:0] pal_q;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TARGET_WIDTH:  width_reg  <= cfg_data;
                CFG_TARGET_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input decode
    assign s_tready     = idle;
    assign in_accept    = s_tvalid && s_tready;
    assign op           = ptb_op_t'(s_tuser);
    assign load_address = s_tdata[11:0];
    assign load_data    = s_tdata[43:12];
    assign pal_in       = s_tdata[54:52];
    assign start        = in_accept && (op == OP_PLACE);

    always_comb begin
        cmd.tile   = TILE_AW'(s_tdata[51:44]);
        // palette numbers past the end fall back to palette 0
        cmd.pal    = (32'(pal_in) < PALETTE_COUNT) ? pal_in : '0;
        cmd.dx     = s_tdata[65:55];
        cmd.dy     = s_tdata[76:66];
        cmd.eof    = s_tlast;
        cmd.width  = (32'(width_reg) > MAX_TARGET_SIZE) ? SIZE_W'(MAX_TARGET_SIZE)
                                                        : width_reg;
        cmd.height = (32'(height_reg) > MAX_TARGET_SIZE) ? SIZE_W'(MAX_TARGET_SIZE)
                                                         : height_reg;
    end

    // store writes; out-of-range loads are dropped
    assign pat_wr.en   = in_accept && (op == OP_LOAD_PATTERN)
                      && (32'(load_address) < PATTERN_DEPTH);
    assign pat_wr.addr = load_address;
    assign pat_wr.data = load_data[7:0];

    assign pal_wr.en   = in_accept && (op == OP_LOAD_PALETTE)
                      && (32'(load_address) < PALETTE_DEPTH);
    assign pal_wr.addr = load_address[PAL_AW-1:0];
    assign pal_wr.data = load_data;

    ptb_pattern_mem u_pattern (
        .aclk (aclk),
        .wr   (pat_wr),
        .rd   (pat_rd),
        .lo_q (pat_lo),
        .hi_q (pat_hi)
    );

    ptb_palette_mem u_palette (
        .aclk (aclk),
        .wr   (pal_wr),
        .rd   (pal_rd),
        .q    (pal_q)
    );

    ptb_blit_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .cmd      (cmd),
        .idle     (idle),
        .pat_rd   (pat_rd),
        .pat_lo   (pat_lo),
        .pat_hi   (pat_hi),
        .pal_rd   (pal_rd),
        .pal_data (pal_q),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
